// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the battery level block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define BTML_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define BTML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/btml_pkg.sv =====
// ---------------------------------------------------------------------------
// btml_pkg
// Types, constants and level tables of the battery trimmed mean level block.
// ---------------------------------------------------------------------------
package btml_pkg;

    // Field widths.
    localparam int ADC_W = 12;
    localparam int LVL_W = 7;
    localparam int CFG_W = 5;
    localparam int ADC_MAX = (1 << ADC_W) - 1;

    // Batch size limit and the widths that follow from it.
    localparam int MAX_SAMPLES = 16;
    localparam int MIN_SAMPLES = 2;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = $clog2(MAX_SAMPLES * ADC_MAX + 1);
    localparam int DVS_RAW_W = $clog2(MAX_SAMPLES - 1);
    localparam int DVS_W = (DVS_RAW_W > 2) ? DVS_RAW_W : 2;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

    // Plain table used for the first level after reset.
    localparam int PLAIN_FULL = 2050;
    localparam int PLAIN_EMPTY = 1600;
    localparam int PLAIN_BASE = 1550;

    // Banded table with dead zones used for later levels.
    localparam int BAND_FULL = 2060;
    localparam int BAND_EMPTY = 1590;
    localparam int BAND_BASE = 1560;
    localparam int BAND_SPAN = 30;

    localparam int LVL_STEP = 50;
    localparam int LVL_BANDS = 9;
    localparam int LVL_UNIT = 10;
    localparam int LVL_TOP = 100;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LVL
    } t_state;

    // Batch totals from the accumulator.
    typedef struct packed {
        logic             close;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        logic [ADC_W-1:0] min_val;
        logic [ADC_W-1:0] max_val;
    } t_batch;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    // Level from the plain 50-count band table.
    function automatic logic [LVL_W-1:0] plain_level(input logic [ADC_W-1:0] m);
        logic [LVL_W-1:0] lvl;
        lvl = '0;
        if (m >= PLAIN_FULL) begin
            lvl = LVL_W'(LVL_TOP);
        end else if (m >= PLAIN_EMPTY) begin
            for (int k = 1; k <= LVL_BANDS; k++) begin
                if (m >= PLAIN_BASE + LVL_STEP * k) begin
                    lvl = LVL_W'(LVL_UNIT * k);
                end
            end
        end
        return lvl;
    endfunction

    // Level from the banded table; a mean in a dead zone keeps the previous level.
    function automatic logic [LVL_W-1:0] banded_level(input logic [ADC_W-1:0] m,
                                                      input logic [LVL_W-1:0] prev);
        logic [LVL_W-1:0] lvl;
        lvl = prev;
        if (m >= BAND_FULL) begin
            lvl = LVL_W'(LVL_TOP);
        end else if (m <= BAND_EMPTY) begin
            lvl = '0;
        end else begin
            for (int k = 1; k <= LVL_BANDS; k++) begin
                if (m >= BAND_BASE + LVL_STEP * k &&
                    m <= BAND_BASE + LVL_STEP * k + BAND_SPAN) begin
                    lvl = LVL_W'(LVL_UNIT * k);
                end
            end
        end
        return lvl;
    endfunction

endpackage

// ===== sv/battery_trimmed_mean_level_top.sv =====
// ---------------------------------------------------------------------------
// battery_trimmed_mean_level_top
// Battery level estimator: trimmed mean of a batch of ADC samples, mapped to
// a percent in steps of ten with hysteresis.
// ---------------------------------------------------------------------------
// Samples are taken while the input is not stalled. The sample that completes
// a batch starts a bit-serial divide of the trimmed sum by the number of samples
// kept, one quotient bit per cycle; the block takes no new sample from the batch
// close through the divide, the level lookup and the output load. Results wait
// in an output register until taken.
module battery_trimmed_mean_level_top
    import btml_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Sample input channel.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [ADC_W-1:0] i_adc_sample,
    // Result output channel.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ADC_W-1:0] o_mean_value,
    output logic [LVL_W-1:0] o_battery_level,
    // Configuration write channel.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_sample_count
);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_sample_count;
    logic             r_out_valid;
    logic [ADC_W-1:0] r_mean;
    logic [LVL_W-1:0] r_last_level;
    logic             r_level_known;
    logic             w_take;
    logic             w_out_load;
    logic [ADC_W-1:0] w_mean;
    logic [LVL_W-1:0] w_level;
    t_batch           w_batch;
    t_div_req         w_req;
    t_div_rsp         w_rsp;

    // Configuration register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_sample_count <= i_cfg_sample_count;
        end
    end

    // Samples are taken only while the sequencer is idle and no batch is being closed.
    assign o_in_stall = (r_state != ST_IDLE) || w_batch.close;
    assign w_take     = i_in_valid && !o_in_stall;

    btml_acc u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_sample       (i_adc_sample),
        .i_sample_count (r_sample_count),
        .o_batch        (w_batch)
    );

    // Trimmed operands; a batch of two is simply halved.
    always_comb begin
        w_req.start = (r_state == ST_IDLE) && w_batch.close;
        if (w_batch.cnt >= CNT_W'(3)) begin
            w_req.dividend = w_batch.sum - SUM_W'(w_batch.min_val)
                             - SUM_W'(w_batch.max_val);
            w_req.divisor  = DVS_W'(w_batch.cnt - CNT_W'(2));
        end else begin
            w_req.dividend = w_batch.sum;
            w_req.divisor  = DVS_W'(2);
        end
    end

    btml_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Level lookup on the finished quotient.
    assign w_mean  = w_rsp.quotient[ADC_W-1:0];
    assign w_level = r_level_known ? banded_level(w_mean, r_last_level)
                                   : plain_level(w_mean);

    // Sequencer: next state and output load.
    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_batch.close) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_rsp.done) begin
                    n_state = ST_LVL;
                end
            end
            ST_LVL: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register and level history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_level  <= '0;
            r_level_known <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid   <= 1'b1;
            r_last_level  <= w_level;
            r_level_known <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mean <= w_mean;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mean_value    = r_mean;
    assign o_battery_level = r_last_level;

endmodule

// ===== sv/btml_acc.sv =====
// ---------------------------------------------------------------------------
// btml_acc
// Sample accumulator: running sum, minimum, maximum and count of one batch.
// ---------------------------------------------------------------------------
module btml_acc
    import btml_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [ADC_W-1:0] i_sample,
    input  logic [CFG_W-1:0] i_sample_count,
    output t_batch           o_batch
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [ADC_W-1:0] r_min, n_min;
    logic [ADC_W-1:0] r_max, n_max;
    logic             r_close, n_close;
    logic [CNT_W-1:0] w_bsize;

    // Effective batch size, clamped to the supported range.
    always_comb begin
        if (i_sample_count < MIN_SAMPLES) begin
            w_bsize = CNT_W'(MIN_SAMPLES);
        end else if (i_sample_count > MAX_SAMPLES) begin
            w_bsize = CNT_W'(MAX_SAMPLES);
        end else begin
            w_bsize = CNT_W'(i_sample_count);
        end
    end

    // Fold in a sample; a closed batch is cleared at the end of the cycle in which it is handed on.
    always_comb begin
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_min   = r_min;
        n_max   = r_max;
        n_close = 1'b0;
        if (r_close) begin
            n_cnt = '0;
            n_sum = '0;
            n_min = ADC_W'(ADC_MAX);
            n_max = '0;
        end else if (i_take) begin
            n_cnt = r_cnt + 1'b1;
            n_sum = r_sum + SUM_W'(i_sample);
            if (i_sample < r_min) begin
                n_min = i_sample;
            end
            if (i_sample > r_max) begin
                n_max = i_sample;
            end
            n_close = (n_cnt >= w_bsize);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_min   <= ADC_W'(ADC_MAX);
            r_max   <= '0;
            r_close <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_min   <= n_min;
            r_max   <= n_max;
            r_close <= n_close;
        end
    end

    assign o_batch.close   = r_close;
    assign o_batch.cnt     = r_cnt;
    assign o_batch.sum     = r_sum;
    assign o_batch.min_val = r_min;
    assign o_batch.max_val = r_max;

endmodule

// ===== sv/btml_div.sv =====
// ---------------------------------------------------------------------------
// btml_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module btml_div
    import btml_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [SUM_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    w_trial;
    logic              w_ge;
    logic [DVS_W-1:0]  w_rem;

    // Shift the next dividend bit into the remainder and try the subtraction.
    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        if (w_ge) begin
            w_rem = DVS_W'(w_trial - {1'b0, r_dvs});
        end else begin
            w_rem = w_trial[DVS_W-1:0];
        end
    end

    // Control: step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Data path: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/btml_chk.sv =====
// ---------------------------------------------------------------------------
// btml_chk
// Port-level checks of the battery level block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module btml_chk
    import btml_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [ADC_W-1:0] o_mean_value,
    input logic [LVL_W-1:0] o_battery_level
);

    // A result that is held back keeps its values.
    `BTML_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_mean_value) && $stable(o_battery_level)), "stalled result changed")

    // A reported level is a multiple of ten up to one hundred.
    `BTML_ASSERT(a_level_step, i_clk, i_rst_n, o_out_valid |-> (o_battery_level == 7'd0 || o_battery_level == 7'd10 || o_battery_level == 7'd20 || o_battery_level == 7'd30 || o_battery_level == 7'd40 || o_battery_level == 7'd50 || o_battery_level == 7'd60 || o_battery_level == 7'd70 || o_battery_level == 7'd80 || o_battery_level == 7'd90 || o_battery_level == 7'd100), "level out of range")

    // A new result never appears right after a sample transaction.
    `BTML_ASSERT(a_no_early_out, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid), "result too soon after sample")

    // Reset clears any pending result.
    `BTML_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind battery_trimmed_mean_level_top btml_chk u_btml_chk (.*);
